// ----- rtl/fst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_pkg
// Shared widths, defaults and codes of the flow socket hash table.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int NUM_BUCKETS_DEF = 256;
  localparam int CHAIN_DEPTH_DEF = 4;

  localparam int KEY_W  = 48;
  localparam int SOCK_W = 16;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int ENT_W  = KEY_W + 2 * SOCK_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

endpackage

// ----- rtl/fst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/fst_mod_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_mod_unit
// Bucket index of a flow key: key modulo the bucket count, three 16-bit key
// digits through one shared multiplier (reciprocal multiply, then multiply
// and subtract), or a plain mask for a power-of-two count.
// ----------------------------------------------------------------------------
module fst_mod_unit
  import fst_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int BW          = $clog2(NUM_BUCKETS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [BW-1:0]    bucket_o
);

  localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
  localparam int DIG_W   = 16;
  localparam int NDIG    = KEY_W / DIG_W;
  localparam int CNT_W   = $clog2(NDIG);

  logic          done_q;
  logic [BW-1:0] rem_q;

  assign done_o   = done_q;
  assign bucket_o = rem_q;

  if (IS_POW2) begin : g_mask
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= key_i[BW-1:0];
      end
    end
  end else begin : g_iter
    // exact quotient of a 32-bit value by the bucket count
    localparam int          SH    = 32 + BW;
    localparam logic [32:0] RECIP = 33'(((64'd1 << SH) / 64'(NUM_BUCKETS)) + 64'd1);
    localparam logic [32:0] DIV_V = 33'(NUM_BUCKETS);

    logic             busy_q;
    logic             phase_q;
    logic [CNT_W-1:0] cnt_q;
    logic [KEY_W-1:0] shreg_q;
    logic [64:0]      prod_q;
    logic [31:0]      x;
    logic [31:0]      quot;
    logic [31:0]      mul_a;
    logic [32:0]      mul_b;
    logic [64:0]      mul_p;
    logic [BW-1:0]    rem_next;

    always_comb begin
      x        = {16'(rem_q), shreg_q[KEY_W-1 -: DIG_W]};
      quot     = 32'(prod_q >> SH);
      mul_a    = phase_q ? quot : x;
      mul_b    = phase_q ? DIV_V : RECIP;
      mul_p    = 65'(mul_a) * 65'(mul_b);
      rem_next = BW'(x - mul_p[31:0]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q  <= 1'b0;
        phase_q <= 1'b0;
        done_q  <= 1'b0;
        cnt_q   <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q  <= 1'b1;
          phase_q <= 1'b0;
          cnt_q   <= CNT_W'(NDIG - 1);
        end else if (busy_q) begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            if (cnt_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q - CNT_W'(1);
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q   <= '0;
        shreg_q <= key_i;
      end else if (busy_q) begin
        if (!phase_q) begin
          prod_q <= mul_p;
        end else begin
          rem_q   <= rem_next;
          shreg_q <= {shreg_q[KEY_W-DIG_W-1:0], {DIG_W{1'b0}}};
        end
      end
    end
  end

endmodule

// ----- rtl/flow_socket_hash_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_socket_hash_table_unit
// Exact-match table from a 48-bit flow key to a server/client socket pair.
// ----------------------------------------------------------------------------
// One item is worked at a time and gives one result. The bucket index comes
// from the remainder unit: a plain mask for a power-of-two bucket count, else
// three 16-bit key digits, each a reciprocal multiply and then a multiply and
// subtract on one shared multiplier. After that the bucket fill is read
// (S_FILL_RD, S_FILL_WT), and the single key comparator walks the bucket one
// slot per cycle through the registered read of the entry memory; a delete
// then moves each younger entry down, a read state and a write state per
// entry. An insert or a lookup in an empty bucket ends after the fill read,
// a search hit or any miss ends when the scan stops, and a delete hit ends
// once the younger entries are moved down; the reserved opcode goes straight
// to the response. The next item is taken the cycle after the result is
// loaded; a finished result waits while an earlier one is still stalled in
// the output register. After reset the bucket fill memory is cleared, one
// bucket a cycle, so the block takes no item until every bucket is cleared.
// ----------------------------------------------------------------------------
module flow_socket_hash_table_unit
  import fst_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [KEY_W-1:0]  flow_key_i,
  input  logic [SOCK_W-1:0] server_socket_i,
  input  logic [SOCK_W-1:0] client_socket_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [SOCK_W-1:0] found_server_o,
  output logic [SOCK_W-1:0] found_client_o
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int FW = $clog2(CHAIN_DEPTH + 1);
  localparam int ED = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int AW = $clog2(ED);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MOD      = 4'd2;
  localparam logic [3:0] S_FILL_RD  = 4'd3;
  localparam logic [3:0] S_FILL_WT  = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_SHIFT_RD = 4'd6;
  localparam logic [3:0] S_SHIFT_WR = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0]        state_q, state_d;
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [SOCK_W-1:0] srv_q, cli_q;
  logic [BW-1:0]     bucket_q, bucket_d;
  logic [AW-1:0]     base_q, base_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     slot_q, slot_d;
  logic [BW-1:0]     clr_q, clr_d;
  status_e           res_status_q, res_status_d;
  logic [SOCK_W-1:0] res_srv_q, res_srv_d, res_cli_q, res_cli_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_status_q;
  logic [SOCK_W-1:0] out_srv_q, out_cli_q;
  logic              out_load;

  logic              accept;
  logic              mod_start, mod_done;
  logic [BW-1:0]     mod_bucket;

  logic              fill_we;
  logic [BW-1:0]     fill_waddr;
  logic [FW-1:0]     fill_wdata, fill_rdata;

  logic              ent_we;
  logic [AW-1:0]     ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              key_match;
  logic [FW-1:0]     slot_inc;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign key_match   = (ent_rdata[ENT_W-1 -: KEY_W] == key_q);
  assign slot_inc    = slot_q + FW'(1);
  assign mod_start   = accept && (op_e'(opcode_i) != OP_NOP);

  fst_mod_unit #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BW          (BW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .key_i    (flow_key_i),
    .done_o   (mod_done),
    .bucket_o (mod_bucket)
  );

  fst_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_BUCKETS),
    .AW    (BW)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (bucket_q),
    .rdata_o (fill_rdata)
  );

  fst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ED),
    .AW    (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    state_d      = state_q;
    bucket_d     = bucket_q;
    base_d       = base_q;
    fill_d       = fill_q;
    slot_d       = slot_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_srv_d    = res_srv_q;
    res_cli_d    = res_cli_q;
    out_load     = 1'b0;
    fill_we      = 1'b0;
    fill_waddr   = bucket_q;
    fill_wdata   = '0;
    ent_we       = 1'b0;
    ent_waddr    = base_q + AW'(slot_q);
    ent_wdata    = ent_rdata;
    ent_raddr    = base_q + AW'(slot_inc);

    unique case (state_q)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        clr_d      = clr_q + BW'(1);
        if (clr_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_srv_d    = '0;
          res_cli_d    = '0;
          if (op_e'(opcode_i) == OP_NOP) begin
            state_d = S_RESP;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bucket_d = mod_bucket;
          state_d  = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        base_d  = AW'(bucket_q) * AW'(CHAIN_DEPTH);
        state_d = S_FILL_WT;
      end
      S_FILL_WT: begin
        fill_d = fill_rdata;
        slot_d = '0;
        if (op_q == OP_INSERT) begin
          if (fill_rdata >= FW'(CHAIN_DEPTH)) begin
            res_status_d = ST_FULL;
          end else begin
            ent_we     = 1'b1;
            ent_waddr  = base_q + AW'(fill_rdata);
            ent_wdata  = {key_q, srv_q, cli_q};
            fill_we    = 1'b1;
            fill_wdata = fill_rdata + FW'(1);
          end
          state_d = S_RESP;
        end else if (fill_rdata == '0) begin
          res_status_d = ST_MISS;
          state_d      = S_RESP;
        end else begin
          ent_raddr = base_q;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_match) begin
          if (op_q == OP_SEARCH) begin
            res_srv_d = ent_rdata[2*SOCK_W-1 -: SOCK_W];
            res_cli_d = ent_rdata[SOCK_W-1:0];
            state_d   = S_RESP;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else if (slot_inc == fill_q) begin
          res_status_d = ST_MISS;
          state_d      = S_RESP;
        end else begin
          slot_d = slot_inc;
        end
      end
      S_SHIFT_RD: begin
        if (slot_inc < fill_q) begin
          state_d = S_SHIFT_WR;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = fill_q - FW'(1);
          state_d    = S_RESP;
        end
      end
      S_SHIFT_WR: begin
        ent_we  = 1'b1;
        slot_d  = slot_inc;
        state_d = S_SHIFT_RD;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(opcode_i);
      key_q <= flow_key_i;
      srv_q <= server_socket_i;
      cli_q <= client_socket_i;
    end
    bucket_q     <= bucket_d;
    base_q       <= base_d;
    fill_q       <= fill_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_srv_q    <= res_srv_d;
    res_cli_q    <= res_cli_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_srv_q    <= res_srv_q;
      out_cli_q    <= res_cli_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_server_o = out_srv_q;
  assign found_client_o = out_cli_q;

endmodule

// ----- rtl/fst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks of the flow socket hash table, bound to the top level.
// ----------------------------------------------------------------------------
module fst_checker
  import fst_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [OP_W-1:0]   opcode_i,
  input logic [KEY_W-1:0]  flow_key_i,
  input logic [SOCK_W-1:0] server_socket_i,
  input logic [SOCK_W-1:0] client_socket_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ST_W-1:0]   status_o,
  input logic [SOCK_W-1:0] found_server_o,
  input logic [SOCK_W-1:0] found_client_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(found_server_o) && $stable(found_client_o))
    else $error("stalled result item changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_MISS) || (status_o == ST_FULL))
    else $error("undefined status code");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (found_server_o == '0) && (found_client_o == '0))
    else $error("sockets nonzero on miss or full");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

endmodule

bind flow_socket_hash_table_unit fst_checker u_fst_checker (.*);
